[hdl/vdi_pkg.sv]
// shared types, constants and the square root step for vector_distance_isqrt
// no dependencies; vdi_root and vector_distance_isqrt import this package
package vdi_pkg;

    // command codes
    typedef enum logic [1:0] {
        CMD_FIXED_3D = 2'd0,
        CMD_FIXED_H  = 2'd1,
        CMD_INT_3D   = 2'd2,
        CMD_ROOT     = 2'd3
    } t_cmd;

    localparam int FRACTION_BITS_DEF = 16;
    localparam int ROOT_STAGES       = 16;
    localparam logic [16:0] DIST_MAX  = 17'h1FFFF;
    localparam logic [63:0] SUM_LIMIT = 64'h0000_0000_7FFF_FFFF;

    // input word
    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic [30:0]        radicand;
    } t_in_word;

    // result word
    typedef struct packed {
        logic [16:0] distance;
        logic        overflow;
    } t_out_word;

    // sideband through the first root
    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] sq_y;
        logic        ovf;
    } t_side1;

    // sideband through the second root
    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] h;
        logic        ovf;
    } t_side2;

    // partial root and remainder
    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] root;
    } t_rstate;

    // two restoring root digits, taking four radicand bits
    function automatic t_rstate root_step2(t_rstate s, logic [3:0] bits);
        t_rstate     q;
        logic [35:0] cur;
        logic [35:0] trial;
        q = s;
        for (int k = 0; k < 2; k++) begin
            cur   = {q.rem, bits[3-2*k -: 2]};
            trial = {2'b00, q.root, 2'b01};
            if (cur >= trial) begin
                q.rem  = 34'(cur - trial);
                q.root = {q.root[30:0], 1'b1};
            end else begin
                q.rem  = cur[33:0];
                q.root = {q.root[30:0], 1'b0};
            end
        end
        return q;
    endfunction

endpackage

[hdl/vdi_chan.sv]
// valid/ready channel carrying one word of type T
// depends on nothing; payload types come from vdi_pkg at instantiation
interface vdi_chan #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/vdi_root.sv]
// pipelined 64-bit floor square root, two digits per stage, sideband carried along
// depends on vdi_pkg
module vdi_root
    import vdi_pkg::*;
#(
    parameter type T_SIDE = logic
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [63:0] i_value,
    input  T_SIDE       i_side,
    output logic        o_valid,
    output logic [31:0] o_root,
    output T_SIDE       o_side
);

    logic    r_vld  [ROOT_STAGES];
    t_rstate r_st   [ROOT_STAGES];
    logic [63:0] r_val [ROOT_STAGES];
    T_SIDE   r_side [ROOT_STAGES];

    genvar g;
    generate
        for (g = 0; g < ROOT_STAGES; g++) begin : g_stage
            logic        w_vld;
            t_rstate     w_st;
            logic [63:0] w_val;
            T_SIDE       w_side;

            // stage input from the previous stage or the ports
            if (g == 0) begin : g_first
                assign w_vld  = i_valid;
                assign w_st   = '0;
                assign w_val  = i_value;
                assign w_side = i_side;
            end else begin : g_next
                assign w_vld  = r_vld[g-1];
                assign w_st   = r_st[g-1];
                assign w_val  = r_val[g-1];
                assign w_side = r_side[g-1];
            end

            // valid bit
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[g] <= 1'b0;
                end else if (i_en) begin
                    r_vld[g] <= w_vld;
                end
            end

            // two digits per stage
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_st[g]   <= root_step2(w_st, w_val[63:60]);
                    r_val[g]  <= {w_val[59:0], 4'b0000};
                    r_side[g] <= w_side;
                end
            end
        end
    endgenerate

    assign o_valid = r_vld[ROOT_STAGES-1];
    assign o_root  = r_st[ROOT_STAGES-1].root;
    assign o_side  = r_side[ROOT_STAGES-1];

endmodule

[hdl/vector_distance_isqrt.sv]
// vector_distance_isqrt: 3d / horizontal distance and plain root, fully pipelined
// throughput: one word per cycle; a stall at the output freezes the whole pipeline
// the two 16-stage root pipelines (two digits per stage) set the depth
// reset: synchronous active-low i_rst_n clears all valid bits, pipeline empty
// depends on vdi_pkg, vdi_chan, vdi_root
module vector_distance_isqrt
    import vdi_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    vdi_chan.sink   i_in,
    vdi_chan.source o_out
);

    logic w_adv;

    // stage 1: differences
    logic               r1_vld;
    logic [1:0]         r1_cmd;
    logic signed [31:0] r1_dx, r1_dy, r1_dz;
    logic [30:0]        r1_rad;
    // stage 2: magnitudes
    logic        r2_vld;
    logic [1:0]  r2_cmd;
    logic [31:0] r2_mx, r2_my, r2_mz;
    logic [30:0] r2_rad;
    // stage 3: squares
    logic        r3_vld;
    logic [1:0]  r3_cmd;
    logic [63:0] r3_sx, r3_sy, r3_sz;
    logic [30:0] r3_rad;
    // stage 4: first sum
    logic        r4_vld;
    logic [63:0] r4_sum;
    t_side1      r4_side;
    // first root output
    logic        w_r1_vld;
    logic [31:0] w_h;
    t_side1      w_side1;
    // stage 5: h squared
    logic        r5_vld;
    logic [63:0] r5_hsq;
    logic [31:0] r5_h;
    t_side1      r5_side;
    // stage 6: second sum
    logic        r6_vld;
    logic [63:0] r6_sum;
    t_side2      r6_side;
    // second root output
    logic        w_r2_vld;
    logic [31:0] w_d;
    t_side2      w_side2;
    // output register
    logic        r7_vld;
    t_out_word   r7_word;

    logic signed [31:0] w_dx, w_dy, w_dz;
    logic [31:0] w_root_sel;
    logic [64:0] w_sum1, w_sum2;

    // the whole pipeline moves unless a finished word waits
    assign w_adv       = !r7_vld || o_out.ready;
    assign i_in.ready  = w_adv;
    assign o_out.valid = r7_vld;
    assign o_out.data  = r7_word;

    // coordinate differences per command
    always_comb begin
        logic signed [31:0] ex, ey, ez;
        ex = i_in.data.a_x - i_in.data.b_x;
        ey = i_in.data.a_y - i_in.data.b_y;
        ez = i_in.data.a_z - i_in.data.b_z;
        if (i_in.data.command == CMD_INT_3D) begin
            w_dx = 32'(signed'(17'(signed'(i_in.data.a_x[15:0]))
                   - 17'(signed'(i_in.data.b_x[15:0]))));
            w_dy = 32'(signed'(17'(signed'(i_in.data.a_y[15:0]))
                   - 17'(signed'(i_in.data.b_y[15:0]))));
            w_dz = 32'(signed'(17'(signed'(i_in.data.a_z[15:0]))
                   - 17'(signed'(i_in.data.b_z[15:0]))));
        end else begin
            w_dx = ex >>> FRACTION_BITS;
            w_dy = ey >>> FRACTION_BITS;
            w_dz = ez >>> FRACTION_BITS;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
        end else if (w_adv) begin
            r1_vld <= i_in.valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= w_r1_vld;
            r6_vld <= r5_vld;
            r7_vld <= w_r2_vld;
        end
    end

    assign w_sum1 = {1'b0, r3_sx} + {1'b0, r3_sz};
    assign w_sum2 = {1'b0, r5_side.sq_y} + {1'b0, r5_hsq};
    assign w_root_sel = (w_side2.cmd == CMD_FIXED_H || w_side2.cmd == CMD_ROOT)
                        ? w_side2.h : w_d;

    // front stages: differences, magnitudes, squares, first sum
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_cmd <= i_in.data.command;
            r1_dx  <= w_dx;
            r1_dy  <= w_dy;
            r1_dz  <= w_dz;
            r1_rad <= i_in.data.radicand;

            r2_cmd <= r1_cmd;
            r2_mx  <= r1_dx[31] ? 32'(-r1_dx) : 32'(r1_dx);
            r2_my  <= r1_dy[31] ? 32'(-r1_dy) : 32'(r1_dy);
            r2_mz  <= r1_dz[31] ? 32'(-r1_dz) : 32'(r1_dz);
            r2_rad <= r1_rad;

            r3_cmd <= r2_cmd;
            r3_sx  <= 64'(r2_mx) * 64'(r2_mx);
            r3_sy  <= 64'(r2_my) * 64'(r2_my);
            r3_sz  <= 64'(r2_mz) * 64'(r2_mz);
            r3_rad <= r2_rad;

            r4_side.cmd  <= r3_cmd;
            r4_side.sq_y <= r3_sy;
            if (r3_cmd == CMD_ROOT) begin
                r4_sum       <= {33'd0, r3_rad};
                r4_side.ovf  <= 1'b0;
            end else begin
                r4_sum       <= w_sum1[63:0];
                r4_side.ovf  <= ({1'b0, SUM_LIMIT} < w_sum1);
            end
        end
    end

    // horizontal root
    vdi_root #(.T_SIDE(t_side1)) u_root_h (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r4_vld),
        .i_value (r4_sum),
        .i_side  (r4_side),
        .o_valid (w_r1_vld),
        .o_root  (w_h),
        .o_side  (w_side1)
    );

    // back stages: h squared, second sum, select and saturate
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r5_hsq  <= 64'(w_h) * 64'(w_h);
            r5_h    <= w_h;
            r5_side <= w_side1;

            r6_sum      <= w_sum2[63:0];
            r6_side.cmd <= r5_side.cmd;
            r6_side.h   <= r5_h;
            r6_side.ovf <= r5_side.ovf
                           || ((r5_side.cmd == CMD_FIXED_3D || r5_side.cmd == CMD_INT_3D)
                               && ({1'b0, SUM_LIMIT} < w_sum2));

            r7_word.distance <= (w_root_sel > 32'(DIST_MAX)) ? DIST_MAX : w_root_sel[16:0];
            r7_word.overflow <= w_side2.ovf;
        end
    end

    // full root
    vdi_root #(.T_SIDE(t_side2)) u_root_d (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r6_vld),
        .i_value (r6_sum),
        .i_side  (r6_side),
        .o_valid (w_r2_vld),
        .o_root  (w_d),
        .o_side  (w_side2)
    );

    // an empty output register never holds off the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r7_vld |-> i_in.ready)
        else $error("input stalled with empty output register");

    // a plain root never reports overflow
    a_root_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_r2_vld && w_side2.cmd == CMD_ROOT) |-> !w_side2.ovf)
        else $error("overflow flagged on plain root");

    // a stalled pipeline keeps its last root stage
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(w_r2_vld) && $stable(w_d))
        else $error("root pipeline moved during stall");

endmodule
